// ===== design/keyed_record_table_with_fresh_flags_assert.svh =====
// assertion macros for the keyed record table
// used by the control module, no other dependencies
`ifndef KEYED_RECORD_TABLE_WITH_FRESH_FLAGS_ASSERT_SVH
`define KEYED_RECORD_TABLE_WITH_FRESH_FLAGS_ASSERT_SVH

// same-cycle implication
`define KRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("krt check failed");

// next-cycle implication
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("krt check failed");

`endif

// ===== design/krt_pkg.sv =====
// shared types and constants for the keyed record table
// no dependencies
`default_nettype none

package krt_pkg;

    localparam int TABLE_DEPTH = 16;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_DRAIN  = 2'd2
    } krt_mode_t;

    typedef enum logic [2:0] {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_INSERTED = 3'd2,
        STAT_UPDATED  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_DRAINED  = 3'd5,
        STAT_NONE     = 3'd6
    } krt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } krt_state_t;

    typedef struct packed {
        logic [15:0] battery;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_z;
        logic [31:0] stamp;
    } krt_data_t;

    typedef struct packed {
        logic [7:0] id;
        krt_data_t  data;
    } krt_rec_t;

    typedef struct packed {
        krt_rec_t wdata;
        logic     store_en;
        logic     clr_en;
        logic     drain;
    } krt_cmd_t;

    typedef struct packed {
        logic     hit;
        logic     free;
        logic     fresh;
        logic     fresh2;
        krt_rec_t rec;
    } krt_chain_t;

endpackage

`default_nettype wire

// ===== design/krt_cell.sv =====
// one table slot: key, fresh flag and record, with priority chain links
// depends on krt_pkg
`default_nettype none

module krt_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  krt_pkg::krt_cmd_t   cmd,
    input  wire                 hit_any,
    input  krt_pkg::krt_chain_t chain_in,
    output krt_pkg::krt_chain_t chain_out
);
    import krt_pkg::*;

    logic [7:0] key_reg;
    logic [7:0] key_next;
    logic       fresh_reg;
    logic       fresh_next;
    krt_data_t  data_reg;

    logic match;
    logic free;
    logic fresh_ok;
    logic hit_sel;
    logic free_sel;
    logic fresh_sel;
    logic pick;
    logic we;

    always_comb
    begin
        match     = (key_reg != 8'd0) && (key_reg == cmd.wdata.id);
        free      = (key_reg == 8'd0);
        fresh_ok  = fresh_reg && (key_reg != 8'd0);
        hit_sel   = match && !chain_in.hit;
        free_sel  = free && !chain_in.free;
        fresh_sel = fresh_ok && !chain_in.fresh;
        pick      = cmd.drain ? fresh_sel : hit_sel;
        we        = cmd.store_en && (hit_any ? hit_sel : free_sel);

        chain_out.hit    = chain_in.hit | match;
        chain_out.free   = chain_in.free | free;
        chain_out.fresh  = chain_in.fresh | fresh_ok;
        chain_out.fresh2 = chain_in.fresh2 | (fresh_ok & chain_in.fresh);
        if (pick)
        begin
            chain_out.rec.id   = key_reg;
            chain_out.rec.data = data_reg;
        end
        else
        begin
            chain_out.rec = chain_in.rec;
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        fresh_next = fresh_reg;
        if (we)
        begin
            key_next   = cmd.wdata.id;
            fresh_next = 1'b1;
        end
        else if (cmd.clr_en && fresh_sel)
        begin
            fresh_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= 8'd0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            key_reg   <= key_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            data_reg <= cmd.wdata.data;
        end
    end

endmodule

`default_nettype wire

// ===== design/krt_ctrl.sv =====
// sequencer and result register for the keyed record table
// depends on krt_pkg and the assertion macro header
`default_nettype none
`include "keyed_record_table_with_fresh_flags_assert.svh"

module krt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          mode,
    input  wire  [7:0]          record_id,
    input  wire  [15:0]         battery_level,
    input  wire  [31:0]         accel_x_word,
    input  wire  [31:0]         accel_y_word,
    input  wire  [31:0]         accel_z_word,
    input  wire  [31:0]         now_tick,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [2:0]          status,
    output logic [7:0]          out_id,
    output logic [15:0]         out_battery,
    output logic [31:0]         out_accel_x,
    output logic [31:0]         out_accel_y,
    output logic [31:0]         out_accel_z,
    output logic [31:0]         out_stamp,
    output logic                last_of_run,
    output krt_pkg::krt_cmd_t   cmd,
    input  krt_pkg::krt_chain_t chain_end
);
    import krt_pkg::*;

    krt_state_t  state_reg;
    krt_state_t  state_next;
    logic        op_store_reg;
    krt_rec_t    op_rec_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    krt_status_t out_status_reg;
    krt_rec_t    out_rec_reg;
    logic        out_last_reg;

    logic        accept;
    logic        op_ok;
    logic        out_free;
    logic        out_load;
    krt_status_t res_status;
    krt_rec_t    res_rec;
    logic        res_last;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg != S_IDLE) && out_free;

    always_comb
    begin
        case (krt_mode_t'(mode))
            MODE_LOOKUP: op_ok = 1'b1;
            MODE_STORE:  op_ok = (record_id != 8'd0);
            MODE_DRAIN:  op_ok = 1'b1;
            default:     op_ok = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op_ok)
                begin
                    state_next = (krt_mode_t'(mode) == MODE_DRAIN) ? S_DRAIN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (out_load && !chain_end.fresh2)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        cmd.wdata    = op_rec_reg;
        cmd.store_en = 1'b0;
        cmd.clr_en   = 1'b0;
        cmd.drain    = 1'b0;
        res_status   = STAT_MISS;
        res_rec      = '0;
        res_last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                res_status = STAT_MISS;
            end
            S_EXEC:
            begin
                cmd.store_en = op_store_reg && out_free;
                if (!op_store_reg)
                begin
                    if (chain_end.hit)
                    begin
                        res_status = STAT_HIT;
                        res_rec    = chain_end.rec;
                    end
                end
                else if (chain_end.hit)
                begin
                    res_status = STAT_UPDATED;
                    res_rec    = op_rec_reg;
                end
                else if (chain_end.free)
                begin
                    res_status = STAT_INSERTED;
                    res_rec    = op_rec_reg;
                end
                else
                begin
                    res_status = STAT_FULL;
                end
            end
            S_DRAIN:
            begin
                cmd.drain  = 1'b1;
                cmd.clr_en = out_free;
                if (chain_end.fresh)
                begin
                    res_status = STAT_DRAINED;
                    res_rec    = chain_end.rec;
                    res_last   = !chain_end.fresh2;
                end
                else
                begin
                    res_status = STAT_NONE;
                end
            end
            default:
            begin
                res_status = STAT_MISS;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_store_reg               <= (krt_mode_t'(mode) == MODE_STORE);
            op_rec_reg.id              <= record_id;
            op_rec_reg.data.battery    <= battery_level;
            op_rec_reg.data.accel_x    <= accel_x_word;
            op_rec_reg.data.accel_y    <= accel_y_word;
            op_rec_reg.data.accel_z    <= accel_z_word;
            op_rec_reg.data.stamp      <= now_tick;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_rec_reg    <= res_rec;
            out_last_reg   <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign out_id      = out_rec_reg.id;
    assign out_battery = out_rec_reg.data.battery;
    assign out_accel_x = out_rec_reg.data.accel_x;
    assign out_accel_y = out_rec_reg.data.accel_y;
    assign out_accel_z = out_rec_reg.data.accel_z;
    assign out_stamp   = out_rec_reg.data.stamp;
    assign last_of_run = out_last_reg;

    `KRT_ASSERT_NOW(a_store_clr_excl, clk, rst_n, cmd.store_en, !cmd.clr_en)
    `KRT_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !cmd.store_en && !cmd.clr_en)
    `KRT_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_valid_reg)
    `KRT_ASSERT_NEXT(a_drain_more, clk, rst_n,
        state_reg == S_DRAIN && out_load && chain_end.fresh2,
        state_reg == S_DRAIN && chain_end.fresh)

endmodule

`default_nettype wire

// ===== design/keyed_record_table_with_fresh_flags.sv =====
// keyed record table with fresh flags
// This block keeps TABLE_DEPTH telemetry records keyed by an 8-bit node id (id 0 = free).
// Input channel in_valid/in_ready carries mode, record_id and the record fields; the
// output channel out_valid/out_ready carries one result per transfer.
// Lookup and store: the item is taken in the idle state, the key compare runs along the
// row of slot cells in the exec state, and the result is registered.
// Store with id 0 and mode 3 are taken and dropped in the same cycle, no result.
// Drain: once taken, one result per cycle unless out_ready stalls, for every fresh
// slot in index order (last_of_run on the final one), or one "none fresh" result.
// The row of cells resolves first match, first free and first fresh slot by a
// priority chain, so the key compare and slot selection lie on the combinational path.
// A new item is taken only once the previous one has put its last result into
// the output register; that register holds while out_ready is low, stalling the
// block, and a finished result may wait there while the next item is taken.
// Reset (rst_n, asynchronous) clears every key and fresh flag: all slots free.
// depends on krt_pkg, krt_ctrl and krt_cell
`default_nettype none

module keyed_record_table_with_fresh_flags (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  mode,
    input  wire  [7:0]  record_id,
    input  wire  [15:0] battery_level,
    input  wire  [31:0] accel_x_word,
    input  wire  [31:0] accel_y_word,
    input  wire  [31:0] accel_z_word,
    input  wire  [31:0] now_tick,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  status,
    output logic [7:0]  out_id,
    output logic [15:0] out_battery,
    output logic [31:0] out_accel_x,
    output logic [31:0] out_accel_y,
    output logic [31:0] out_accel_z,
    output logic [31:0] out_stamp,
    output logic        last_of_run
);
    import krt_pkg::*;

    krt_cmd_t   cmd;
    krt_chain_t chain [TABLE_DEPTH+1];

    assign chain[0] = '0;

    krt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .record_id     (record_id),
        .battery_level (battery_level),
        .accel_x_word  (accel_x_word),
        .accel_y_word  (accel_y_word),
        .accel_z_word  (accel_z_word),
        .now_tick      (now_tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_id        (out_id),
        .out_battery   (out_battery),
        .out_accel_x   (out_accel_x),
        .out_accel_y   (out_accel_y),
        .out_accel_z   (out_accel_z),
        .out_stamp     (out_stamp),
        .last_of_run   (last_of_run),
        .cmd           (cmd),
        .chain_end     (chain[TABLE_DEPTH])
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_slot
        krt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .hit_any   (chain[TABLE_DEPTH].hit),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for keyed_record_table_with_fresh_flags
// predicts lookup, store and drain results in its own table copy, checks each transfer
// depends on krt_pkg and the keyed_record_table_with_fresh_flags rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int MAX_DRAIN_RUN = 16;
    localparam int RANDOM_ITEMS = 225;
    localparam int HOLD_FIRST_AT = 60;
    localparam int HOLD_SECOND_AT = 200;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_OUT_CYCLES = 40;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] id;
        krt_data_t  data;
        int         gap;
        bit         hold;
    } table_item_t;

    typedef struct {
        krt_status_t status;
        logic [7:0]  id;
        krt_data_t   data;
        logic        last;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic [7:0]  record_id = '0;
    logic [15:0] battery_level = '0;
    logic [31:0] accel_x_word = '0;
    logic [31:0] accel_y_word = '0;
    logic [31:0] accel_z_word = '0;
    logic [31:0] now_tick = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  out_id;
    logic [15:0] out_battery;
    logic [31:0] out_accel_x;
    logic [31:0] out_accel_y;
    logic [31:0] out_accel_z;
    logic [31:0] out_stamp;
    logic        last_of_run;

    table_item_t   stim_q[$];
    table_result_t predicted_results[$];
    table_item_t   live_item;

    logic [7:0] tbl_key[TABLE_DEPTH] = '{default: '0};
    krt_data_t  tbl_data[TABLE_DEPTH] = '{default: '0};
    bit         tbl_fresh[TABLE_DEPTH] = '{default: 1'b0};

    int accepted_items = 0;
    int idle_left = 0;
    int ready_left = 0;
    int stall_left = 0;
    int long_holds = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int results_checked = 0;
    int status_seen[7] = '{default: 0};

    keyed_record_table_with_fresh_flags DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .record_id    (record_id),
        .battery_level(battery_level),
        .accel_x_word (accel_x_word),
        .accel_y_word (accel_y_word),
        .accel_z_word (accel_z_word),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_id       (out_id),
        .out_battery  (out_battery),
        .out_accel_x  (out_accel_x),
        .out_accel_y  (out_accel_y),
        .out_accel_z  (out_accel_z),
        .out_stamp    (out_stamp),
        .last_of_run  (last_of_run)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic krt_data_t rand_data();
        krt_data_t d;
        d.battery = 16'($urandom_range(0, 16'hFFFF));
        d.accel_x = $urandom;
        d.accel_y = $urandom;
        d.accel_z = $urandom;
        d.stamp   = $urandom;
        return d;
    endfunction

    function automatic void add_item(logic [1:0] m, logic [7:0] id, krt_data_t d, int gap,
                                     bit hold);
        table_item_t it;
        it.mode = m;
        it.id   = id;
        it.data = d;
        it.gap  = gap;
        it.hold = hold;
        stim_q.push_back(it);
    endfunction

    function automatic int find_slot(logic [7:0] id);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_key[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void push_slot(krt_status_t st, int idx, logic last);
        table_result_t r;
        r.status = st;
        r.id     = tbl_key[idx];
        r.data   = tbl_data[idx];
        r.last   = last;
        predicted_results.push_back(r);
    endfunction

    function automatic void push_empty(krt_status_t st);
        table_result_t r;
        r.status = st;
        r.id     = '0;
        r.data   = '0;
        r.last   = 1'b1;
        predicted_results.push_back(r);
    endfunction

    function automatic void apply_table_op(table_item_t it);
        int slot;
        int n;
        krt_status_t st;
        slot = -1;
        n = 0;
        case (it.mode)
            MODE_LOOKUP:
            begin
                if (it.id != 8'd0)
                    slot = find_slot(it.id);
                if (slot < 0)
                    push_empty(STAT_MISS);
                else
                    push_slot(STAT_HIT, slot, 1'b1);
            end
            MODE_STORE:
            begin
                if (it.id != 8'd0)
                begin
                    st = STAT_UPDATED;
                    slot = find_slot(it.id);
                    if (slot < 0)
                    begin
                        st = STAT_INSERTED;
                        slot = find_slot(8'd0);
                    end
                    if (slot < 0)
                        push_empty(STAT_FULL);
                    else
                    begin
                        tbl_key[slot]   = it.id;
                        tbl_data[slot]  = it.data;
                        tbl_fresh[slot] = 1'b1;
                        push_slot(st, slot, 1'b1);
                    end
                end
            end
            MODE_DRAIN:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (n < MAX_DRAIN_RUN && tbl_fresh[i] && tbl_key[i] != 8'd0)
                    begin
                        push_slot(STAT_DRAINED, i, 1'b0);
                        tbl_fresh[i] = 1'b0;
                        n++;
                    end
                end
                if (n == 0)
                    push_empty(STAT_NONE);
                else
                    predicted_results[predicted_results.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        bit offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_table_op(live_item);
                accepted_items <= accepted_items + 1;
            end
            if (!in_valid || in_ready)
            begin
                offer = 1'b0;
                if (idle_left > 0)
                    idle_left--;
                else if (stim_q.size() > 0 &&
                         !(stim_q[0].hold && predicted_results.size() > 0))
                begin
                    live_item = stim_q.pop_front();
                    idle_left = live_item.gap;
                    offer = 1'b1;
                end
                in_valid <= offer;
                if (offer)
                begin
                    mode          <= live_item.mode;
                    record_id     <= live_item.id;
                    battery_level <= live_item.data.battery;
                    accel_x_word  <= live_item.data.accel_x;
                    accel_y_word  <= live_item.data.accel_y;
                    accel_z_word  <= live_item.data.accel_z;
                    now_tick      <= live_item.data.stamp;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_pacer
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_left = 0;
            stall_left = 0;
            long_holds = 0;
        end
        else
        begin
            if (long_holds < 2 &&
                accepted_items >= (long_holds == 0 ? HOLD_FIRST_AT : HOLD_SECOND_AT))
            begin
                stall_left = LONG_HOLD_CYCLES;
                ready_left = 0;
                long_holds++;
            end
            if (stall_left == 0 && ready_left == 0)
            begin
                stall_left = pick_gap();
                ready_left = $urandom_range(1, 40);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                ready_left--;
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t unexpected result: status %0d id %h", $time, status, out_id);
                error_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                check_field("status", 32'(want.status), 32'(status));
                check_field("out_id", 32'(want.id), 32'(out_id));
                check_field("out_battery", 32'(want.data.battery), 32'(out_battery));
                check_field("out_accel_x", want.data.accel_x, out_accel_x);
                check_field("out_accel_y", want.data.accel_y, out_accel_y);
                check_field("out_accel_z", want.data.accel_z, out_accel_z);
                check_field("out_stamp", want.data.stamp, out_stamp);
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t timeout: no transfer for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int effective;
        int k;
        int r;
        logic [1:0] m;
        logic [7:0] id;
        // directed: empty table, reserved id, ignored items, insert, update, full table
        add_item(MODE_DRAIN, 8'd0, '0, pick_gap(), 1'b0);
        add_item(MODE_LOOKUP, 8'd0, '0, pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'd0, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_RESERVED, 8'd5, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'd1, '1, pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'hFF, '0, pick_gap(), 1'b0);
        add_item(MODE_LOOKUP, 8'd1, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_LOOKUP, 8'd0, '1, pick_gap(), 1'b0);
        add_item(MODE_LOOKUP, 8'd77, '0, pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'd1, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_DRAIN, 8'hFF, '1, pick_gap(), 1'b0);
        for (k = 2; k < TABLE_DEPTH; k++)
            add_item(MODE_STORE, k[7:0], rand_data(), pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'd200, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_STORE, 8'd7, rand_data(), pick_gap(), 1'b0);
        add_item(MODE_DRAIN, 8'd0, rand_data(), pick_gap(), 1'b1);

        effective = 0;
        k = 0;
        while (effective < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)
                m = MODE_STORE;
            else if (r < 75)
                m = MODE_LOOKUP;
            else if (r < 92)
                m = MODE_DRAIN;
            else
                m = MODE_RESERVED;
            r = $urandom_range(0, 99);
            if (r < 60)
                id = 8'($urandom_range(1, 16));
            else if (r < 68)
                id = 8'hFF;
            else if (r < 72)
                id = 8'd0;
            else
                id = 8'($urandom_range(0, 255));
            add_item(m, id, rand_data(), ((k / 30) % 3 == 1) ? 0 : pick_gap(), k % 50 == 49);
            if (m != MODE_RESERVED && !(m == MODE_STORE && id == 8'd0))
                effective++;
            k++;
        end

        wait (rst_n);
        while (stim_q.size() > 0 || in_valid || predicted_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_OUT_CYCLES) @(posedge clk);

        $display("run: %0d items accepted, %0d results checked", accepted_items,
                 results_checked);
        $display("hit %0d miss %0d insert %0d update %0d full %0d drained %0d none %0d",
                 status_seen[STAT_HIT], status_seen[STAT_MISS], status_seen[STAT_INSERTED],
                 status_seen[STAT_UPDATED], status_seen[STAT_FULL],
                 status_seen[STAT_DRAINED], status_seen[STAT_NONE]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
